FILE: hdl/lkc_pkg.sv
// Shared types and constants for the LRU keyed entry cache.
// No dependencies; every other file of the block imports this package.
package lkc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = 5;
  localparam int SLOT_W  = 4;
  localparam int KEY_W   = 32;
  localparam int STAMP_W = 32;
  localparam int SIDE_W  = 13;
  localparam int AREA_W  = 2 * SIDE_W;
  localparam int BYTES_W = 31;

  localparam logic [SIDE_W-1:0] MAX_SIDE = 13'd4096;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  typedef struct packed {
    logic load_req;
    logic load_cfg;
    logic lookup;
    logic miss_mode;
    logic scan_start;
    logic scan_step;
    logic evict;
    logic insert;
    logic load_result;
  } lkc_cmd_t;

  typedef struct packed {
    logic miss;
    logic over;
    logic scan_last;
    logic out_free;
  } lkc_status_t;

endpackage

FILE: hdl/lkc_if.sv
// Valid/ready channel interfaces for requests, results and the limit register.
// Depends on lkc_pkg for field widths.
interface lkc_req_if import lkc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [KEY_W-1:0]  key;
  logic [SIDE_W-1:0] width;
  logic [SIDE_W-1:0] height;

  modport source (output valid, func, key, width, height, input ready);
  modport sink (input valid, func, key, width, height, output ready);
endinterface

interface lkc_rsp_if import lkc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               hit;
  logic [SLOT_W-1:0]  slot;
  logic [SIDE_W-1:0]  entry_width;
  logic [SIDE_W-1:0]  entry_height;
  logic               evicted;
  logic [KEY_W-1:0]   evicted_key;
  logic [CNT_W-1:0]   entry_count;
  logic [BYTES_W-1:0] memory_bytes;

  modport source (output valid, hit, slot, entry_width, entry_height, evicted, evicted_key,
                  entry_count, memory_bytes, input ready);
  modport sink (input valid, hit, slot, entry_width, entry_height, evicted, evicted_key,
                entry_count, memory_bytes, output ready);
endinterface

interface lkc_cfg_if import lkc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] entry_limit;

  modport source (output valid, entry_limit, input ready);
  modport sink (input valid, entry_limit, output ready);
endinterface

FILE: hdl/lkc_ctrl.sv
// Controller state machine of the LRU keyed entry cache.
// Depends on lkc_pkg for the command and status structs.
module lkc_ctrl import lkc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  output lkc_cmd_t    cmd,
  input  lkc_status_t st
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_CHECK,
    S_SCAN,
    S_EVICT,
    S_INSERT,
    S_RESULT
  } state_t;

  state_t state, state_next;
  logic   miss_mode, miss_mode_next;

  always_comb begin
    state_next     = state;
    miss_mode_next = miss_mode;
    cmd            = '0;
    cmd.miss_mode  = miss_mode;
    req_ready      = 1'b0;
    cfg_ready      = 1'b0;
    unique case (state)
      S_IDLE: begin
        cfg_ready = 1'b1;
        req_ready = !cfg_valid;
        if (cfg_valid) begin
          cmd.load_cfg   = 1'b1;
          miss_mode_next = 1'b0;
          state_next     = S_CHECK;
        end else if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_CMP;
        end
      end
      S_CMP: begin
        cmd.lookup = 1'b1;
        if (st.miss) begin
          miss_mode_next = 1'b1;
          state_next     = S_CHECK;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_CHECK: begin
        if (st.over) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else if (miss_mode) begin
          state_next = S_INSERT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_last) begin
          state_next = S_EVICT;
        end
      end
      S_EVICT: begin
        cmd.evict  = 1'b1;
        state_next = S_CHECK;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (st.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      miss_mode <= 1'b0;
    end else begin
      state     <= state_next;
      miss_mode <= miss_mode_next;
    end
  end

endmodule

FILE: hdl/lkc_datapath.sv
// Datapath of the LRU keyed entry cache: entry registers, parallel key compare,
// stamp scan, shift on removal, byte total and the result register. Uses lkc_pkg.
module lkc_datapath import lkc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  lkc_cmd_t          cmd,
  output lkc_status_t       st,
  input  logic              in_func,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [SIDE_W-1:0] in_width,
  input  logic [SIDE_W-1:0] in_height,
  input  logic [CNT_W-1:0]  cfg_limit,
  lkc_rsp_if.source         rsp
);

  logic [KEY_W-1:0]   key_mem   [ENTRIES];
  logic [STAMP_W-1:0] stamp_mem [ENTRIES];
  logic [SIDE_W-1:0]  wid_mem   [ENTRIES];
  logic [SIDE_W-1:0]  hgt_mem   [ENTRIES];

  logic               req_func;
  logic [KEY_W-1:0]   req_key;
  logic [SIDE_W-1:0]  req_w;
  logic [SIDE_W-1:0]  req_h;
  logic [CNT_W-1:0]   limit;
  logic [CNT_W-1:0]   fill;
  logic [STAMP_W-1:0] clock;
  logic [BYTES_W-1:0] bytes;
  logic [IDX_W-1:0]   rd_idx;
  logic [IDX_W-1:0]   pick;
  logic [STAMP_W-1:0] best_stamp;
  logic [KEY_W-1:0]   best_key;
  logic [SIDE_W-1:0]  best_w;
  logic [SIDE_W-1:0]  best_h;
  logic               hit_r;
  logic               ev_flag;
  logic [KEY_W-1:0]   ev_key;
  logic               out_valid;

  logic [ENTRIES-1:0] match;
  logic               any_match;
  logic [IDX_W-1:0]   found;
  logic [CNT_W-1:0]   eff_limit;
  logic [CNT_W-1:0]   thr;
  logic [CNT_W-1:0]   fill_m1;
  logic [SIDE_W-1:0]  mul_a;
  logic [SIDE_W-1:0]  mul_b;
  logic [AREA_W-1:0]  area;
  logic [BYTES_W-1:0] delta;
  logic               take;
  logic [STAMP_W-1:0] clock_inc;
  logic [IDX_W-1:0]   fill_idx;

  always_comb begin
    match     = '0;
    any_match = 1'b0;
    found     = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = (CNT_W'(i) < fill) && (key_mem[i] == req_key);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        found     = IDX_W'(i);
        any_match = 1'b1;
      end
    end
  end

  assign eff_limit = (limit > CNT_W'(ENTRIES)) ? CNT_W'(ENTRIES) : limit;
  assign thr       = cmd.miss_mode ? ((eff_limit == '0) ? '0 : eff_limit - 1'b1) : eff_limit;
  assign fill_m1   = fill - 1'b1;
  assign fill_idx  = fill[IDX_W-1:0];
  assign clock_inc = clock + 1'b1;

  assign mul_a = cmd.insert ? req_w : best_w;
  assign mul_b = cmd.insert ? req_h : best_h;
  assign area  = AREA_W'(mul_a) * AREA_W'(mul_b);
  assign delta = {3'b000, area, 2'b00};

  assign take = (rd_idx == '0) || (stamp_mem[rd_idx] < best_stamp);

  assign st.miss      = (req_func == FUNC_LOOKUP) && !any_match;
  assign st.over      = fill > thr;
  assign st.scan_last = CNT_W'(rd_idx) == fill_m1;
  assign st.out_free  = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (cmd.lookup && req_func == FUNC_LOOKUP && any_match) begin
      stamp_mem[found] <= clock_inc;
    end
    if (cmd.evict) begin
      for (int i = 0; i < ENTRIES - 1; i++) begin
        if (IDX_W'(i) >= pick) begin
          key_mem[i]   <= key_mem[i+1];
          stamp_mem[i] <= stamp_mem[i+1];
          wid_mem[i]   <= wid_mem[i+1];
          hgt_mem[i]   <= hgt_mem[i+1];
        end
      end
    end
    if (cmd.insert) begin
      key_mem[fill_idx]   <= req_key;
      stamp_mem[fill_idx] <= clock_inc;
      wid_mem[fill_idx]   <= req_w;
      hgt_mem[fill_idx]   <= req_h;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_func <= in_func;
      req_key  <= in_key;
      req_w    <= (in_width > MAX_SIDE) ? MAX_SIDE : in_width;
      req_h    <= (in_height > MAX_SIDE) ? MAX_SIDE : in_height;
    end
    if (cmd.scan_step && take) begin
      best_stamp <= stamp_mem[rd_idx];
      best_key   <= key_mem[rd_idx];
      best_w     <= wid_mem[rd_idx];
      best_h     <= hgt_mem[rd_idx];
      pick       <= rd_idx;
    end
    if (cmd.load_result) begin
      if (req_func == FUNC_CLEAR) begin
        rsp.hit          <= 1'b0;
        rsp.slot         <= '0;
        rsp.entry_width  <= '0;
        rsp.entry_height <= '0;
        rsp.evicted      <= 1'b0;
        rsp.evicted_key  <= '0;
      end else begin
        rsp.hit          <= hit_r;
        rsp.slot         <= SLOT_W'(rd_idx);
        rsp.entry_width  <= wid_mem[rd_idx];
        rsp.entry_height <= hgt_mem[rd_idx];
        rsp.evicted      <= ev_flag;
        rsp.evicted_key  <= ev_key;
      end
      rsp.entry_count  <= fill;
      rsp.memory_bytes <= bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit     <= CNT_W'(ENTRIES);
      fill      <= '0;
      clock     <= '0;
      bytes     <= '0;
      rd_idx    <= '0;
      hit_r     <= 1'b0;
      ev_flag   <= 1'b0;
      ev_key    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_cfg) begin
        limit <= cfg_limit;
      end
      if (cmd.load_req) begin
        hit_r   <= 1'b0;
        ev_flag <= 1'b0;
        ev_key  <= '0;
      end
      if (cmd.lookup) begin
        if (req_func == FUNC_CLEAR) begin
          fill  <= '0;
          bytes <= '0;
          clock <= '0;
        end else if (any_match) begin
          clock  <= clock_inc;
          rd_idx <= found;
          hit_r  <= 1'b1;
        end
      end
      if (cmd.scan_start) begin
        rd_idx <= '0;
      end
      if (cmd.scan_step) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (cmd.evict) begin
        fill    <= fill_m1;
        bytes   <= bytes - delta;
        ev_flag <= 1'b1;
        ev_key  <= best_key;
      end
      if (cmd.insert) begin
        fill   <= fill + 1'b1;
        clock  <= clock_inc;
        bytes  <= bytes + delta;
        rd_idx <= fill_idx;
        hit_r  <= 1'b0;
      end
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid = out_valid;

endmodule

FILE: hdl/lru_keyed_entry_cache.sv
// Top level: a hit or a clear passes from the compare state to the result register; a miss
// passes through the compare and check states and, while the fill has reached the limit, a
// one-entry-a-cycle stamp scan that removes the least recently used entry, then inserts the
// new entry. A limit write removes least recently used entries the same way until within it.
// One request is worked on at a time, and a stalled result holds the controller.
// Reset clears the controller, the counters and the limit (16); entries need no reset.
module lru_keyed_entry_cache import lkc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  lkc_req_if.sink   req,
  lkc_rsp_if.source rsp,
  lkc_cfg_if.sink   cfg
);

  lkc_cmd_t    cmd;
  lkc_status_t st;

  lkc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .cmd       (cmd),
    .st        (st)
  );

  lkc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_func   (req.func),
    .in_key    (req.key),
    .in_width  (req.width),
    .in_height (req.height),
    .cfg_limit (cfg.entry_limit),
    .rsp       (rsp)
  );

endmodule

FILE: hdl/lkc_checker.sv
// Port-level checks for the LRU keyed entry cache, bound to the top level.
// Depends on lkc_pkg and on the top level's ports.
module lkc_checker import lkc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic               rsp_hit,
  input logic [SLOT_W-1:0]  rsp_slot,
  input logic               rsp_evicted,
  input logic [KEY_W-1:0]   rsp_evicted_key,
  input logic [CNT_W-1:0]   rsp_entry_count,
  input logic [BYTES_W-1:0] rsp_memory_bytes
);

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_entry_count <= CNT_W'(ENTRIES))
    else $error("Entry count above capacity.");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_hit |-> !rsp_evicted && rsp_evicted_key == '0)
    else $error("A hit reported an eviction.");

  a_slot_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_entry_count != '0 |-> CNT_W'(rsp_slot) < rsp_entry_count)
    else $error("Returned slot lies beyond the filled entries.");

  a_empty_bytes: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_entry_count == '0 |-> rsp_memory_bytes == '0 && !rsp_hit)
    else $error("An empty cache reports bytes in use or a hit.");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot))
    else $error("A stalled result changed.");

endmodule

bind lru_keyed_entry_cache lkc_checker u_lkc_checker (
  .clk              (clk),
  .rst              (rst),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_hit          (rsp.hit),
  .rsp_slot         (rsp.slot),
  .rsp_evicted      (rsp.evicted),
  .rsp_evicted_key  (rsp.evicted_key),
  .rsp_entry_count  (rsp.entry_count),
  .rsp_memory_bytes (rsp.memory_bytes)
);
